// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the event tracker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check a property on rising clock edges outside of reset.
`define ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/lsat_pkg.sv =====
// ----------------------------------------------------------------------------
// lsat_pkg
// Types, codes and constants of the loud sound and alarm event tracker.
// ----------------------------------------------------------------------------
package lsat_pkg;

    // Defaults of the top level parameters
    localparam int unsigned HOLD_SECONDS_DEF = 10;
    localparam int unsigned QUEUE_DEPTH_DEF  = 2;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEAST_DB8   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOST_DB8    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 3'd4;

    // Register reset values
    localparam logic [2:0]  ENABLE_RESET   = 3'd0;
    localparam logic [6:0]  SENS_RESET     = 7'd100;
    localparam logic [7:0]  LEAST_RESET    = 8'd61;
    localparam logic [7:0]  MOST_RESET     = 8'd20;
    localparam logic [15:0] COOLDOWN_RESET = 16'd300;

    // Item kinds
    localparam logic OP_AUDIO = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Event codes
    localparam logic [2:0] EV_SMOKE_START = 3'd0;
    localparam logic [2:0] EV_SMOKE_STOP  = 3'd1;
    localparam logic [2:0] EV_CO_START    = 3'd2;
    localparam logic [2:0] EV_CO_STOP     = 3'd3;
    localparam logic [2:0] EV_LOUD_START  = 3'd4;
    localparam logic [2:0] EV_LOUD_STOP   = 3'd5;

    // Detector arithmetic
    localparam logic [6:0]  PCT_FULL     = 7'd100;
    localparam logic [7:0]  LEVEL_WINDOW = 8'd8;
    localparam logic [3:0]  ELAPSED_MAX  = 4'd15;
    // x / 100 == (x * 5243) >> 19 for every x below 25501
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int unsigned DIV100_SHIFT = 19;
    // Cycles the threshold pipeline needs after a register write
    localparam logic [1:0]  THR_SETTLE   = 2'd3;

    localparam int unsigned MAX_EVENTS = 3;

    typedef struct packed {
        logic       op;
        logic [7:0] level_db8;
        logic       smoke_seen;
        logic       co_seen;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_code;
        logic       last;
    } t_out_item;

    // Events of one audio block, packed from slot zero upward
    typedef struct packed {
        logic [1:0]                 count;
        logic [MAX_EVENTS-1:0][2:0] code;
    } t_evt_batch;

endpackage

// ===== rtl/lsat_front.sv =====
// ----------------------------------------------------------------------------
// lsat_front
// Holds the configuration and the detector state, takes input items and
// turns each audio block into a batch of up to three events.
// ----------------------------------------------------------------------------
module lsat_front #(
    parameter int unsigned HOLD_SECONDS = lsat_pkg::HOLD_SECONDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lsat_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lsat_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  lsat_pkg::t_in_item                i_in_data,
    input  logic                              i_q_full,
    output logic                              o_push,
    output lsat_pkg::t_evt_batch              o_push_data
);
    import lsat_pkg::*;

    localparam logic [3:0] HOLD_LIMIT = 4'(HOLD_SECONDS);

    // Configuration registers
    logic [2:0]  r_enable;
    logic [6:0]  r_sens;
    logic [7:0]  r_least;
    logic [7:0]  r_most;
    logic [15:0] r_cooldown;

    // Threshold pipeline
    logic [14:0] r_span_prod, n_span_prod;
    logic [27:0] r_quot_prod, n_quot_prod;
    logic [7:0]  r_thr, n_thr;
    logic [1:0]  r_settle, n_settle;
    logic [6:0]  sens_sat;
    logic [6:0]  pct_rem;
    logic [7:0]  span;

    // Detector state
    logic [7:0]  r_prev, n_prev;
    logic [7:0]  r_start, n_start;
    logic [3:0]  r_elapsed, n_elapsed;
    logic [2:0]  r_flags, n_flags;
    logic        r_cd_active, n_cd_active;
    logic [15:0] r_cd_remain, n_cd_remain;

    logic        accept;
    logic        floor_pass;
    logic        hold_hit;
    logic        rise_hit;
    logic        loud_hit;
    logic [2:0]  result;
    logic [2:0]  change;
    logic [1:0]  ev_cnt;
    t_evt_batch  batch;

    // Threshold: (100 - s) * max(least - most, 0) / 100 + most
    always_comb begin
        sens_sat    = (r_sens > PCT_FULL) ? PCT_FULL : r_sens;
        pct_rem     = PCT_FULL - sens_sat;
        span        = (r_least > r_most) ? (r_least - r_most) : 8'd0;
        n_span_prod = {8'd0, pct_rem} * {7'd0, span};
        n_quot_prod = {13'd0, r_span_prod} * {15'd0, DIV100_MUL};
        n_thr       = r_quot_prod[DIV100_SHIFT+7:DIV100_SHIFT] + r_most;
        if (i_cfg_we) begin
            n_settle = THR_SETTLE;
        end else if (r_settle != 2'd0) begin
            n_settle = r_settle - 2'd1;
        end else begin
            n_settle = r_settle;
        end
    end

    assign o_in_stall = (r_settle != 2'd0) || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    // Classify the audio block
    always_comb begin
        floor_pass = (r_start < LEVEL_WINDOW) || (i_in_data.level_db8 >= r_start - LEVEL_WINDOW);
        hold_hit   = (r_elapsed < HOLD_LIMIT) && floor_pass;
        rise_hit   = (r_prev != 8'd0) &&
                     ({1'b0, i_in_data.level_db8} > ({1'b0, r_prev} + {1'b0, r_thr}));
        loud_hit   = r_flags[2] ? hold_hit : rise_hit;
        result     = {r_enable[2] & loud_hit,
                      r_enable[1] & i_in_data.co_seen,
                      r_enable[0] & i_in_data.smoke_seen};
        change     = result ^ r_flags;

        // Pack the events in smoke, CO, loud order
        batch  = '0;
        ev_cnt = 2'd0;
        if (change[0]) begin
            batch.code[ev_cnt] = result[0] ? EV_SMOKE_START : EV_SMOKE_STOP;
            ev_cnt = ev_cnt + 2'd1;
        end
        if (change[1]) begin
            batch.code[ev_cnt] = result[1] ? EV_CO_START : EV_CO_STOP;
            ev_cnt = ev_cnt + 2'd1;
        end
        if (change[2] && !r_cd_active) begin
            batch.code[ev_cnt] = result[2] ? EV_LOUD_START : EV_LOUD_STOP;
            ev_cnt = ev_cnt + 2'd1;
        end
        batch.count = ev_cnt;
    end

    assign o_push      = accept && (i_in_data.op == OP_AUDIO) && (ev_cnt != 2'd0);
    assign o_push_data = batch;

    // Next detector state
    always_comb begin
        n_prev      = r_prev;
        n_start     = r_start;
        n_elapsed   = r_elapsed;
        n_flags     = r_flags;
        n_cd_active = r_cd_active;
        n_cd_remain = r_cd_remain;
        if (accept) begin
            if (i_in_data.op == OP_TICK) begin
                // Advance the hold timer and count down the cooldown
                if (r_flags[2] && (r_elapsed < ELAPSED_MAX)) begin
                    n_elapsed = r_elapsed + 4'd1;
                end
                if (r_cd_active) begin
                    if (r_cd_remain <= 16'd1) begin
                        n_cd_active = 1'b0;
                        n_cd_remain = 16'd0;
                    end else begin
                        n_cd_remain = r_cd_remain - 16'd1;
                    end
                end
            end else begin
                if (r_enable[2]) begin
                    n_prev = i_in_data.level_db8;
                    if (!r_flags[2] && rise_hit) begin
                        n_start   = i_in_data.level_db8;
                        n_elapsed = 4'd0;
                    end
                end
                if (change[2] && !r_cd_active && !result[2]) begin
                    n_cd_active = 1'b1;
                    n_cd_remain = r_cooldown;
                end
                n_flags = result;
            end
        end
    end

    // Threshold pipeline registers
    always_ff @(posedge i_clk) begin
        r_span_prod <= n_span_prod;
        r_quot_prod <= n_quot_prod;
        r_thr       <= n_thr;
    end

    // Configuration and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= ENABLE_RESET;
            r_sens      <= SENS_RESET;
            r_least     <= LEAST_RESET;
            r_most      <= MOST_RESET;
            r_cooldown  <= COOLDOWN_RESET;
            r_settle    <= THR_SETTLE;
            r_prev      <= 8'd0;
            r_start     <= 8'd0;
            r_elapsed   <= 4'd0;
            r_flags     <= 3'd0;
            r_cd_active <= 1'b0;
            r_cd_remain <= 16'd0;
        end else begin
            r_settle    <= n_settle;
            r_prev      <= n_prev;
            r_start     <= n_start;
            r_elapsed   <= n_elapsed;
            r_flags     <= n_flags;
            r_cd_active <= n_cd_active;
            r_cd_remain <= n_cd_remain;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ENABLE_MASK: r_enable   <= i_cfg_data[2:0];
                    REG_SENSITIVITY: r_sens     <= i_cfg_data[6:0];
                    REG_LEAST_DB8:   r_least    <= i_cfg_data[7:0];
                    REG_MOST_DB8:    r_most     <= i_cfg_data[7:0];
                    REG_COOLDOWN:    r_cooldown <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/lsat_queue.sv =====
// ----------------------------------------------------------------------------
// lsat_queue
// Small FIFO of event batches between the front and the back.
// ----------------------------------------------------------------------------
module lsat_queue #(
    parameter int unsigned DEPTH = lsat_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lsat_pkg::t_evt_batch i_push_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output lsat_pkg::t_evt_batch o_head
);
    import lsat_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_evt_batch       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/lsat_back.sv =====
// ----------------------------------------------------------------------------
// lsat_back
// Walks the head batch one event per cycle, while the receiver does not stall,
// into the output register and marks the final event of each batch.
// ----------------------------------------------------------------------------
module lsat_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  lsat_pkg::t_evt_batch i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lsat_pkg::t_out_item  o_out_data
);
    import lsat_pkg::*;

    logic       r_out_valid;
    t_out_item  r_out_data;
    logic [1:0] r_idx;
    logic       load;
    logic       is_last;

    assign load    = (!r_out_valid || !i_out_stall) && !i_empty;
    assign is_last = (r_idx == (i_head.count - 2'd1));
    assign o_pop   = load && is_last;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Load the next event, or drop the valid once the event is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_idx       <= is_last ? 2'd0 : r_idx + 2'd1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data.event_code <= i_head.code[r_idx];
            r_out_data.last       <= is_last;
        end
    end

endmodule

// ===== rtl/loud_sound_alarm_event_tracker_top.sv =====
// ----------------------------------------------------------------------------
// loud_sound_alarm_event_tracker_top
// Tracks smoke, CO and loud sound flags and reports their start/stop events.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes audio blocks
//   and one-second ticks, one item per cycle when nothing stalls. An audio
//   block gives zero to three events; a tick gives none.
//   Output channel (o_out_valid / i_out_stall / o_out_data) moves one event
//   per transfer; the final event of an audio block carries last.
//   An item's first event passes through the batch queue and then the
//   output register. The output side sets throughput: the back end emits
//   one event per cycle while the receiver does not stall.
//   A receiver stall holds the output register; the batch queue of
//   QUEUE_DEPTH entries then fills and the input stalls after it.
//   Configuration writes on i_cfg_we / i_cfg_idx / i_cfg_data update the
//   registers at once; the input stalls after each write while the rise
//   threshold is recomputed in its three-stage pipeline.
//   Reset (i_rst_n low, synchronous) loads register defaults, clears all
//   flags and timers and empties the queue; the input stalls after reset
//   for the same threshold pipeline.
// ----------------------------------------------------------------------------
module loud_sound_alarm_event_tracker_top #(
    parameter int unsigned HOLD_SECONDS = lsat_pkg::HOLD_SECONDS_DEF,
    parameter int unsigned QUEUE_DEPTH  = lsat_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lsat_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsat_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  lsat_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lsat_pkg::t_out_item             o_out_data
);
    import lsat_pkg::*;

    logic       q_push;
    t_evt_batch q_push_data;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    t_evt_batch q_head;

    lsat_front #(
        .HOLD_SECONDS(HOLD_SECONDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    lsat_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_head      (q_head)
    );

    lsat_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/lsat_checker.sv =====
// ----------------------------------------------------------------------------
// lsat_checker
// Port-level assertions for the event tracker, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsat_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input lsat_pkg::t_in_item              i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input lsat_pkg::t_out_item             o_out_data
);
    import lsat_pkg::*;

    // Reset empties the output register
    `ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // A stalled input item holds until it is taken
    `ASSERT_RUN(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data), "stalled input changed")

    // A stalled event holds until it is taken
    `ASSERT_RUN(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled event changed")

    // Loud events come last in their block
    `ASSERT_RUN(a_loud_is_last, i_clk, i_rst_n, o_out_valid && (o_out_data.event_code == EV_LOUD_START || o_out_data.event_code == EV_LOUD_STOP) |-> o_out_data.last, "loud event not last")

    // Only defined event codes leave the block
    `ASSERT_RUN(a_code_range, i_clk, i_rst_n, o_out_valid |-> (o_out_data.event_code <= EV_LOUD_STOP), "undefined event code")

endmodule

bind loud_sound_alarm_event_tracker_top lsat_checker u_lsat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== bench/loud_sound_alarm_event_tracker_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loud_sound_alarm_event_tracker_top_tb
// Drives audio blocks and one-second ticks into the event tracker and checks
// every emitted event against an in-bench prediction of the flags, the loud
// sound window and the cooldown. Both channels idle and stall in bursts.
// ----------------------------------------------------------------------------

// Predicts the events of each accepted item and checks the emitted ones in order
class tracker_event_board;
    // Register copies
    logic [2:0]  enable_mask;
    logic [6:0]  sens_pct;
    logic [7:0]  least_db8;
    logic [7:0]  most_db8;
    logic [15:0] cooldown_secs;
    // Detector state
    logic [7:0]  prev_level;
    logic [7:0]  start_level;
    logic [3:0]  elapsed_secs;
    logic [2:0]  alarm_flags;
    logic        cooling;
    logic [15:0] cooling_left;
    // Events still to be seen, oldest first
    lsat_pkg::t_out_item due_events[$];
    int unsigned errors;

    function new();
        enable_mask   = lsat_pkg::ENABLE_RESET;
        sens_pct      = lsat_pkg::SENS_RESET;
        least_db8     = lsat_pkg::LEAST_RESET;
        most_db8      = lsat_pkg::MOST_RESET;
        cooldown_secs = lsat_pkg::COOLDOWN_RESET;
        prev_level    = '0;
        start_level   = '0;
        elapsed_secs  = '0;
        alarm_flags   = '0;
        cooling       = 1'b0;
        cooling_left  = '0;
        errors        = 0;
    endfunction

    function void write_reg(logic [lsat_pkg::CFG_IDX_W-1:0] idx,
                            logic [lsat_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            lsat_pkg::REG_ENABLE_MASK: enable_mask   = data[2:0];
            lsat_pkg::REG_SENSITIVITY: sens_pct      = data[6:0];
            lsat_pkg::REG_LEAST_DB8:   least_db8     = data[7:0];
            lsat_pkg::REG_MOST_DB8:    most_db8      = data[7:0];
            lsat_pkg::REG_COOLDOWN:    cooldown_secs = data[15:0];
            default: ;
        endcase
    endfunction

    // Rise in dB8 that a block must exceed to start a loud sound
    function int rise_threshold();
        int pct;
        int span;
        pct  = (sens_pct > lsat_pkg::PCT_FULL) ? int'(lsat_pkg::PCT_FULL) : int'(sens_pct);
        span = (least_db8 > most_db8) ? int'(least_db8) - int'(most_db8) : 0;
        return ((int'(lsat_pkg::PCT_FULL) - pct) * span) / int'(lsat_pkg::PCT_FULL)
               + int'(most_db8);
    endfunction

    // Start or hold the loud sound and remember the level
    function bit loud_hit(logic [7:0] level);
        bit hit;
        int floor_level;
        hit = 1'b0;
        if (alarm_flags[2]) begin
            floor_level = int'(start_level) - int'(lsat_pkg::LEVEL_WINDOW);
            if (elapsed_secs < lsat_pkg::HOLD_SECONDS_DEF && int'(level) >= floor_level)
                hit = 1'b1;
        end else if (prev_level != 0 &&
                     int'(level) - int'(prev_level) > rise_threshold()) begin
            start_level  = level;
            elapsed_secs = '0;
            hit          = 1'b1;
        end
        prev_level = level;
        return hit;
    endfunction

    // Advance the state by one accepted item and queue the events it causes
    function void take_item(lsat_pkg::t_in_item item);
        logic [2:0] seen;
        logic [2:0] change;
        logic [2:0] codes [3];
        int         n;
        lsat_pkg::t_out_item ev;
        seen = '0;
        n    = 0;
        if (item.op == lsat_pkg::OP_TICK) begin
            if (alarm_flags[2] && elapsed_secs < lsat_pkg::ELAPSED_MAX)
                elapsed_secs++;
            if (cooling) begin
                if (cooling_left <= 1) begin
                    cooling      = 1'b0;
                    cooling_left = '0;
                end else begin
                    cooling_left--;
                end
            end
            return;
        end
        if (enable_mask[0] && item.smoke_seen)
            seen[0] = 1'b1;
        if (enable_mask[1] && item.co_seen)
            seen[1] = 1'b1;
        if (enable_mask[2] && loud_hit(item.level_db8))
            seen[2] = 1'b1;
        change = seen ^ alarm_flags;
        if (change[0]) begin
            codes[n] = seen[0] ? lsat_pkg::EV_SMOKE_START : lsat_pkg::EV_SMOKE_STOP;
            n++;
        end
        if (change[1]) begin
            codes[n] = seen[1] ? lsat_pkg::EV_CO_START : lsat_pkg::EV_CO_STOP;
            n++;
        end
        // Loud changes stay silent while cooling down
        if (change[2] && !cooling) begin
            if (seen[2]) begin
                codes[n] = lsat_pkg::EV_LOUD_START;
            end else begin
                codes[n]     = lsat_pkg::EV_LOUD_STOP;
                cooling      = 1'b1;
                cooling_left = cooldown_secs;
            end
            n++;
        end
        alarm_flags = seen;
        for (int k = 0; k < n; k++) begin
            ev.event_code = codes[k];
            ev.last       = (k == n - 1);
            due_events.push_back(ev);
        end
    endfunction

    function void check_event(lsat_pkg::t_out_item got);
        lsat_pkg::t_out_item want;
        if (due_events.size() == 0) begin
            $error("unexpected event: event_code %0d last %0d", got.event_code, got.last);
            errors++;
            return;
        end
        want = due_events.pop_front();
        if (got.event_code !== want.event_code) begin
            $error("event_code: expected %0d, actual %0d", want.event_code, got.event_code);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return due_events.size();
    endfunction
endclass

module loud_sound_alarm_event_tracker_top_tb;
    import lsat_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned SETTLE_CYCLES  = 6;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;

    tracker_event_board board;
    int unsigned items_sent  = 0;
    int unsigned stall_left  = 0;
    int unsigned idle_cycles = 0;
    bit          quiet_tail  = 1'b0;
    bit          smoke_on    = 1'b0;
    bit          co_on       = 1'b0;

    loud_sound_alarm_event_tracker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Check each event transfer and stall the output in bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            board.check_event(o_out_data);
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!i_out_stall && !quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Stop a hung run: count cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one item, with an occasional idle burst first, and hold it until taken
    task automatic send_item(input t_in_item item);
        int unsigned gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.take_item(item);
        items_sent++;
    endtask

    task automatic send_audio(input logic [7:0] level, input logic smoke, input logic co);
        t_in_item item;
        item.op         = OP_AUDIO;
        item.level_db8  = level;
        item.smoke_seen = smoke;
        item.co_seen    = co;
        send_item(item);
    endtask

    // Tick with random don't-care fields
    task automatic send_tick();
        t_in_item item;
        item.op         = OP_TICK;
        item.level_db8  = 8'($urandom_range(0, 255));
        item.smoke_seen = 1'($urandom_range(0, 1));
        item.co_seen    = 1'($urandom_range(0, 1));
        send_item(item);
    endtask

    // Audio block whose alarm verdicts flip now and then
    task automatic send_block(input int unsigned level);
        if ($urandom_range(0, 3) == 0)
            smoke_on = !smoke_on;
        if ($urandom_range(0, 3) == 0)
            co_on = !co_on;
        send_audio(level[7:0], smoke_on, co_on);
    endtask

    // Drop valid, wait for all outstanding events, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Write every register; unused upper data bits carry random junk
    task automatic configure(input logic [2:0] en, input logic [6:0] sens,
                             input logic [7:0] least, input logic [7:0] most,
                             input logic [15:0] cool);
        logic [15:0] junk;
        junk = 16'($urandom_range(0, 65535));
        write_reg(REG_ENABLE_MASK, {junk[15:3], en});
        write_reg(REG_SENSITIVITY, {junk[15:7], sens});
        write_reg(REG_LEAST_DB8, {junk[15:8], least});
        write_reg(REG_MOST_DB8, {junk[7:0], most});
        write_reg(REG_COOLDOWN, cool);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly loud episodes: quiet base, jump over the threshold, hold, release
    task automatic run_phase(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned kind;
        int unsigned base;
        int unsigned peak;
        int unsigned reps;
        int          thr;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                thr  = board.rise_threshold();
                base = $urandom_range(1, (thr < 250) ? 254 - thr : 1);
                repeat ($urandom_range(1, 2)) send_block(base);
                peak = base + thr + $urandom_range(1, 30);
                if (peak > 255)
                    peak = 255;
                send_block(peak);
                reps = $urandom_range(0, 4);
                for (int k = 0; k < reps; k++) begin
                    if ($urandom_range(0, 1) == 1)
                        send_tick();
                    if ($urandom_range(0, 3) == 0)
                        send_block((peak + $urandom_range(0, 10) > 255) ?
                                   255 : peak + $urandom_range(0, 10));
                    else
                        send_block(peak - $urandom_range(0, (peak >= 8) ? 8 : peak));
                end
                // Sometimes run out the hold window, or saturate the counter
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(9, 17)) send_tick();
                if ($urandom_range(0, 2) != 0)
                    send_block((peak > 9) ? $urandom_range(0, peak - 9) : 0);
                if ($urandom_range(0, 1) == 1)
                    send_tick();
            end else if (kind <= 7) begin
                repeat ($urandom_range(1, 5)) send_tick();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) == 0)
                        send_tick();
                    else
                        send_audio(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial begin
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default threshold of 20, short cooldown
        configure(3'b111, 7'd100, 8'd61, 8'd20, 16'd2);
        send_audio(8'd255, 1'b0, 1'b0);   // no previous level: no start
        send_audio(8'd10, 1'b1, 1'b1);    // smoke and CO start
        send_audio(8'd60, 1'b0, 1'b0);    // three events in one block
        send_audio(8'd54, 1'b1, 1'b0);    // loud holds inside the window
        send_tick();
        send_audio(8'd40, 1'b1, 1'b0);    // loud stop opens the cooldown
        send_audio(8'd200, 1'b1, 1'b0);   // muted start
        send_tick();
        send_audio(8'd100, 1'b1, 1'b0);   // muted stop
        send_tick();                      // cooldown over
        send_audio(8'd150, 1'b0, 1'b1);
        repeat (10) send_tick();
        send_audio(8'd150, 1'b0, 1'b1);   // hold time expired
        drain();

        // Loud only, zero threshold, zero cooldown
        configure(3'b100, 7'd100, 8'd0, 8'd0, 16'd0);
        send_tick();
        send_tick();
        send_audio(8'd1, 1'b1, 1'b1);     // CO now disabled: CO stop
        send_audio(8'd3, 1'b0, 1'b0);     // loud start near zero
        send_audio(8'd0, 1'b0, 1'b0);     // floor below zero: still loud
        drain();

        // Loud disabled while its flag is set
        configure(3'b011, 7'd100, 8'd61, 8'd20, 16'd1);
        send_audio(8'd9, 1'b1, 1'b0);
        drain();

        configure(3'b111, 7'd100, 8'd61, 8'd20, 16'd1);
        run_phase(30);
        drain();
        configure(3'b111, 7'd0, 8'd255, 8'd0, 16'd3);
        run_phase(10);
        drain();
        configure(3'b000, 7'd100, 8'd61, 8'd20, 16'd2);
        run_phase(10);
        drain();
        configure(3'b111, 7'd50, 8'd20, 8'd61, 16'd2);
        run_phase(25);
        drain();
        configure(3'($urandom_range(1, 7)), 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 60)),
                  16'($urandom_range(1, 4)));
        run_phase(25);
        drain();
        configure(3'b111, 7'd127, 8'd255, 8'd0, 16'd2);
        run_phase(20);
        drain();

        // Final stretch at full rate on both sides
        quiet_tail = 1'b1;
        configure(3'b111, 7'd90, 8'd40, 8'd8, 16'd65535);
        run_phase(30);
        drain();

        if (board.errors == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
